// ----- rtl/lcab_pkg.sv -----
// ---------------------------------------------------------------------------
// lcab_pkg: shared definitions for the common ancestor block
// Field widths, operation codes and parameter defaults.
// ---------------------------------------------------------------------------
package lcab_pkg;

  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 11;
  localparam int OP_W    = 2;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam int MAX_NODES_DEF = 1024;
  localparam int LEVELS_DEF    = 10;

  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 10'd1023;

endpackage

// ----- rtl/lca_binary_lifting.sv -----
// ---------------------------------------------------------------------------
// lca_binary_lifting: lowest common ancestor by binary lifting
// Ancestor table and depth store with a sequencer sharing one memory port.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word: opcode with node,
//   parent, depth and other_node. A load word writes one node's parent and
//   depth and is done in the accept cycle. A build word fills ancestor
//   levels 1..LEVELS-1 for nodes 1..min(node_count, MAX_NODES-1). A query
//   word returns one word on the output channel (out_valid/out_ready); the
//   descent over the levels is skipped when the lifted node already meets
//   the other one. Each descent level costs two reads on the single read
//   port of the ancestor memory. One word is in work at a time; in_ready is
//   low until it is done.
//   The configuration channel (cfg_valid/cfg_ready/cfg_data) writes
//   node_count; cfg_ready is always high. Write it only while idle.
//   Reset starts a clearing pass that zeroes the ancestor table; in_ready
//   stays low meanwhile. A stalled receiver holds the result in the output
//   register; the sequencer waits for it to drain before finishing a query.
// ---------------------------------------------------------------------------
module lca_binary_lifting #(
  parameter int MAX_NODES = lcab_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = lcab_pkg::LEVELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lcab_pkg::OP_W-1:0]    opcode,
  input  logic [lcab_pkg::NODE_W-1:0]  node,
  input  logic [lcab_pkg::NODE_W-1:0]  parent,
  input  logic [lcab_pkg::DEPTH_W-1:0] depth,
  input  logic [lcab_pkg::NODE_W-1:0]  other_node,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lcab_pkg::NODE_W-1:0]  common_ancestor,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lcab_pkg::NODE_W-1:0]  cfg_data
);
  import lcab_pkg::*;

  // node index bits and level index bits
  localparam int NAW = $clog2(MAX_NODES);
  localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  logic [NODE_W-1:0]  node_count;
  logic               res_valid;
  logic [NODE_W-1:0]  res_data;
  logic               res_ready;

  logic               anc_we;
  logic [NAW+LW-1:0]  anc_waddr;
  logic [NAW-1:0]     anc_wdata;
  logic [NAW+LW-1:0]  anc_raddr;
  logic [NAW-1:0]     anc_rdata;
  logic               dep_we;
  logic [NAW-1:0]     dep_waddr;
  logic [DEPTH_W-1:0] dep_wdata;
  logic [NAW-1:0]     dep_raddr;
  logic [DEPTH_W-1:0] dep_rdata;

  // configuration register: always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      node_count <= cfg_data;
    end
  end

  // output register: take a new word when empty or draining this cycle
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      common_ancestor <= res_data;
    end
  end

  // ancestor table, addressed {node, level}
  lcab_ram #(
    .DW (NAW),
    .AW (NAW + LW)
  ) u_anc (
    .clk   (clk),
    .we    (anc_we),
    .waddr (anc_waddr),
    .wdata (anc_wdata),
    .raddr (anc_raddr),
    .rdata (anc_rdata)
  );

  // depth per node
  lcab_ram #(
    .DW (DEPTH_W),
    .AW (NAW)
  ) u_dep (
    .clk   (clk),
    .we    (dep_we),
    .waddr (dep_waddr),
    .wdata (dep_wdata),
    .raddr (dep_raddr),
    .rdata (dep_rdata)
  );

  lcab_seq #(
    .MAX_NODES (MAX_NODES),
    .LEVELS    (LEVELS),
    .NAW       (NAW),
    .LW        (LW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .node       (node),
    .parent     (parent),
    .depth      (depth),
    .other_node (other_node),
    .node_count (node_count),
    .res_valid  (res_valid),
    .res_data   (res_data),
    .res_ready  (res_ready),
    .anc_we     (anc_we),
    .anc_waddr  (anc_waddr),
    .anc_wdata  (anc_wdata),
    .anc_raddr  (anc_raddr),
    .anc_rdata  (anc_rdata),
    .dep_we     (dep_we),
    .dep_waddr  (dep_waddr),
    .dep_wdata  (dep_wdata),
    .dep_raddr  (dep_raddr),
    .dep_rdata  (dep_rdata)
  );

endmodule

// ----- rtl/lcab_ram.sv -----
// ---------------------------------------------------------------------------
// lcab_ram: simple dual-port memory
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module lcab_ram #(
  parameter int DW = 10,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/lcab_seq.sv -----
// ---------------------------------------------------------------------------
// lcab_seq: sequencer for load, build and query
// Drives both memories from one state machine and walks the ancestor levels.
// ---------------------------------------------------------------------------
module lcab_seq #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10,
  parameter int NAW       = 10,
  parameter int LW        = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lcab_pkg::OP_W-1:0]    opcode,
  input  logic [lcab_pkg::NODE_W-1:0]  node,
  input  logic [lcab_pkg::NODE_W-1:0]  parent,
  input  logic [lcab_pkg::DEPTH_W-1:0] depth,
  input  logic [lcab_pkg::NODE_W-1:0]  other_node,
  input  logic [lcab_pkg::NODE_W-1:0]  node_count,
  output logic                        res_valid,
  output logic [lcab_pkg::NODE_W-1:0]  res_data,
  input  logic                        res_ready,
  output logic                        anc_we,
  output logic [NAW+LW-1:0]           anc_waddr,
  output logic [NAW-1:0]              anc_wdata,
  output logic [NAW+LW-1:0]           anc_raddr,
  input  logic [NAW-1:0]              anc_rdata,
  output logic                        dep_we,
  output logic [NAW-1:0]              dep_waddr,
  output logic [lcab_pkg::DEPTH_W-1:0] dep_wdata,
  output logic [NAW-1:0]              dep_raddr,
  input  logic [lcab_pkg::DEPTH_W-1:0] dep_rdata
);
  import lcab_pkg::*;

  localparam int AW = NAW + LW;
  localparam logic [LW-1:0] I_LAST = LW'(LEVELS - 1);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_BFIRST = 4'd2;
  localparam logic [3:0] S_BMID   = 4'd3;
  localparam logic [3:0] S_BWR    = 4'd4;
  localparam logic [3:0] S_QDB    = 4'd5;
  localparam logic [3:0] S_QSW    = 4'd6;
  localparam logic [3:0] S_QLIFT  = 4'd7;
  localparam logic [3:0] S_QLIFTW = 4'd8;
  localparam logic [3:0] S_QEQ    = 4'd9;
  localparam logic [3:0] S_QDNB   = 4'd10;
  localparam logic [3:0] S_QDNC   = 4'd11;
  localparam logic [3:0] S_QRES   = 4'd12;
  localparam logic [3:0] S_QOUT   = 4'd13;

  logic [3:0]         state;
  logic [AW-1:0]      clr;
  logic [NAW-1:0]     j;
  logic [LW-1:0]      lvl;
  logic [NAW-1:0]     blast;
  logic [NAW-1:0]     a;
  logic [NAW-1:0]     b;
  logic [NAW-1:0]     ta;
  logic [NAW-1:0]     res;
  logic [DEPTH_W-1:0] da;
  logic [LEVELS-1:0]  dif;
  logic [LW-1:0]      i;

  logic               accept;
  logic               node_ok;
  logic [NAW-1:0]     node_c;
  logic [NAW-1:0]     other_c;
  logic [NAW-1:0]     parent_c;
  logic [NAW-1:0]     build_last;
  logic [NAW-1:0]     j_inc;
  logic [LW-1:0]      lvl_prev;
  logic [LW-1:0]      i_dec;
  logic [NAW-1:0]     a_n;
  logic [NAW-1:0]     b_n;
  logic [DEPTH_W-1:0] gap;

  // out-of-range nodes fold onto the root
  assign node_ok  = 32'(node) < 32'(MAX_NODES);
  assign node_c   = node_ok ? NAW'(node) : '0;
  assign other_c  = (32'(other_node) < 32'(MAX_NODES)) ? NAW'(other_node) : '0;
  assign parent_c = (32'(parent) < 32'(MAX_NODES)) ? NAW'(parent) : '0;
  assign build_last = (32'(node_count) > 32'(MAX_NODES - 1)) ? NAW'(MAX_NODES - 1)
                                                             : NAW'(node_count);

  assign j_inc    = j + 1'b1;
  assign lvl_prev = lvl - 1'b1;
  assign i_dec    = i - 1'b1;
  assign a_n      = (ta != anc_rdata) ? ta : a;
  assign b_n      = (ta != anc_rdata) ? anc_rdata : b;
  assign gap      = (dep_rdata < da) ? DEPTH_W'(da - dep_rdata) : DEPTH_W'(dep_rdata - da);

  assign accept    = in_valid && in_ready;
  assign res_valid = (state == S_QOUT);
  assign res_data  = NODE_W'(res);

  always_comb begin
    in_ready  = (state == S_IDLE);
    anc_we    = 1'b0;
    anc_waddr = {node_c, {LW{1'b0}}};
    anc_wdata = parent_c;
    anc_raddr = {b, i};
    dep_we    = accept && (opcode == OP_LOAD) && node_ok;
    dep_waddr = node_c;
    dep_wdata = depth;
    dep_raddr = (state == S_IDLE) ? node_c : b;
    unique case (state)
      S_CLEAR: begin
        anc_we    = 1'b1;
        anc_waddr = clr;
        anc_wdata = '0;
      end
      S_IDLE: begin
        anc_we = accept && (opcode == OP_LOAD) && node_ok;
      end
      S_BFIRST: anc_raddr = {j, lvl_prev};
      S_BMID:   anc_raddr = {anc_rdata, lvl_prev};
      S_BWR: begin
        anc_we    = 1'b1;
        anc_waddr = {j, lvl};
        anc_wdata = anc_rdata;
        anc_raddr = {j_inc, lvl_prev};
      end
      S_QEQ:  anc_raddr = {a, I_LAST};
      S_QDNC: anc_raddr = (i == '0) ? {a_n, {LW{1'b0}}} : {a_n, i_dec};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (&clr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (opcode)
              OP_BUILD: begin
                if (LEVELS > 1 && build_last != '0) begin
                  j     <= NAW'(1);
                  lvl   <= LW'(1);
                  blast <= build_last;
                  state <= S_BFIRST;
                end
              end
              OP_QUERY: begin
                a     <= node_c;
                b     <= other_c;
                state <= S_QDB;
              end
              default: ;
            endcase
          end
        end
        S_BFIRST: state <= S_BMID;
        S_BMID:   state <= S_BWR;
        S_BWR: begin
          if (j == blast) begin
            if (lvl == I_LAST) begin
              state <= S_IDLE;
            end else begin
              lvl   <= lvl + 1'b1;
              j     <= NAW'(1);
              state <= S_BFIRST;
            end
          end else begin
            j     <= j_inc;
            state <= S_BMID;
          end
        end
        S_QDB: begin
          da    <= dep_rdata;
          state <= S_QSW;
        end
        S_QSW: begin
          // keep b as the deeper node
          if (dep_rdata < da) begin
            a <= b;
            b <= a;
          end
          dif   <= LEVELS'(gap);
          i     <= '0;
          state <= S_QLIFT;
        end
        S_QLIFT: begin
          if (dif[i]) begin
            state <= S_QLIFTW;
          end else if (i == I_LAST) begin
            state <= S_QEQ;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_QLIFTW: begin
          b <= anc_rdata;
          if (i == I_LAST) begin
            state <= S_QEQ;
          end else begin
            i     <= i + 1'b1;
            state <= S_QLIFT;
          end
        end
        S_QEQ: begin
          if (a == b) begin
            res   <= a;
            state <= S_QOUT;
          end else begin
            i     <= I_LAST;
            state <= S_QDNB;
          end
        end
        S_QDNB: begin
          ta    <= anc_rdata;
          state <= S_QDNC;
        end
        S_QDNC: begin
          a <= a_n;
          b <= b_n;
          if (i == '0) begin
            state <= S_QRES;
          end else begin
            i     <= i_dec;
            state <= S_QDNB;
          end
        end
        S_QRES: begin
          res   <= anc_rdata;
          state <= S_QOUT;
        end
        S_QOUT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/lcab_chk.sv -----
// ---------------------------------------------------------------------------
// lcab_chk: port-level checks for the common ancestor block
// Attached to the top level by a bind statement.
// ---------------------------------------------------------------------------
module lcab_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [lcab_pkg::OP_W-1:0]   opcode,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [lcab_pkg::NODE_W-1:0] common_ancestor
);
  import lcab_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(common_ancestor))
    else $error("result word changed while stalled");

  // clearing pass follows reset
  a_clear_busy: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input ready during clearing pass");

  // a query occupies the block
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == OP_QUERY |=> !in_ready)
    else $error("input ready right after query accept");

  // a result only comes out of a query in work
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result word without a query in work");

endmodule

bind lca_binary_lifting lcab_chk u_chk (.*);

// ----- test/tb_lca_binary_lifting.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lca_binary_lifting: self-checking bench for the common ancestor block
// Loads small random trees, builds the doubling levels and asks for common
// ancestors, while a scoreboard mirrors the ancestor table and depth store
// and checks every returned word in order. Runs several node_count settings
// and idling patterns, including a long output stall that backs up the input.
// ---------------------------------------------------------------------------
module tb_lca_binary_lifting;
  import lcab_pkg::*;

  localparam int TREE_NODES  = MAX_NODES_DEF;
  localparam int TREE_LEVELS = LEVELS_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Idling patterns for the two channels
  localparam int IDLE_NONE     = 0;
  localparam int IDLE_SENDER   = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH     = 3;

  localparam int LONG_HOLD   = 400;
  localparam int PHASE_WORDS = 185;
  localparam int CYCLE_LIMIT = 2_000_000;

  // -------------------------------------------------------------------------
  // Scoreboard: mirrors the ancestor table and depths, queues expected
  // ancestors in query order and checks returned words against them.
  // -------------------------------------------------------------------------
  class lca_scoreboard;
    logic [NODE_W-1:0]  jump_tbl [TREE_NODES*TREE_LEVELS];
    logic [DEPTH_W-1:0] node_dep [TREE_NODES];
    logic [NODE_W-1:0]  build_limit;
    logic [NODE_W-1:0]  expected_ancestors [$];
    int                 errors;

    function new();
      for (int k = 0; k < TREE_NODES*TREE_LEVELS; k++) jump_tbl[k] = '0;
      for (int k = 0; k < TREE_NODES; k++) node_dep[k] = '0;
      build_limit = NODE_COUNT_RST;
      errors = 0;
    endfunction

    function int jump(int v, int lvl);
      return int'(jump_tbl[v*TREE_LEVELS + lvl]);
    endfunction

    function void set_node_count(logic [NODE_W-1:0] value);
      build_limit = value;
    endfunction

    function int pending();
      return expected_ancestors.size();
    endfunction

    // Fill one level after another; each level reads only the one below.
    function void fill_levels();
      int last;
      last = int'(build_limit);
      if (last > TREE_NODES-1) last = TREE_NODES-1;
      for (int lvl = 1; lvl < TREE_LEVELS; lvl++)
        for (int v = 1; v <= last; v++)
          jump_tbl[v*TREE_LEVELS + lvl] = jump_tbl[jump(v, lvl-1)*TREE_LEVELS + lvl-1];
    endfunction

    function logic [NODE_W-1:0] lowest_common(int a, int b);
      int                 t;
      logic [DEPTH_W-1:0] gap;
      if (node_dep[b] < node_dep[a]) begin
        t = a;
        a = b;
        b = t;
      end
      gap = node_dep[b] - node_dep[a];
      // Lift the deeper node; gap bits at the level count and above drop out.
      for (int lvl = 0; lvl < TREE_LEVELS; lvl++)
        if (gap[lvl]) b = jump(b, lvl);
      if (a == b) return NODE_W'(a);
      for (int lvl = TREE_LEVELS-1; lvl >= 0; lvl--) begin
        if (jump(a, lvl) != jump(b, lvl)) begin
          a = jump(a, lvl);
          b = jump(b, lvl);
        end
      end
      return NODE_W'(jump(a, 0));
    endfunction

    function void note_word(logic [OP_W-1:0] op, logic [NODE_W-1:0] nd,
                            logic [NODE_W-1:0] par, logic [DEPTH_W-1:0] dp,
                            logic [NODE_W-1:0] oth);
      int a, b;
      a = (int'(nd) < TREE_NODES) ? int'(nd) : 0;
      b = (int'(oth) < TREE_NODES) ? int'(oth) : 0;
      case (op)
        OP_LOAD: begin
          if (int'(nd) < TREE_NODES) begin
            jump_tbl[a*TREE_LEVELS] = (int'(par) < TREE_NODES) ? par : '0;
            node_dep[a] = dp;
          end
        end
        OP_BUILD: fill_levels();
        OP_QUERY: expected_ancestors.push_back(lowest_common(a, b));
        default: ;
      endcase
    endfunction

    function void check_result(logic [NODE_W-1:0] got);
      logic [NODE_W-1:0] want;
      if (expected_ancestors.size() == 0) begin
        errors++;
        $display("%0t: common_ancestor expected none got %0d", $time, got);
        return;
      end
      want = expected_ancestors.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: common_ancestor expected %0d got %0d", $time, want, got);
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Block under test
  // -------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [OP_W-1:0]    opcode;
  logic [NODE_W-1:0]  node;
  logic [NODE_W-1:0]  parent;
  logic [DEPTH_W-1:0] depth;
  logic [NODE_W-1:0]  other_node;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [NODE_W-1:0]  common_ancestor;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [NODE_W-1:0]  cfg_data;

  lca_binary_lifting dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .node            (node),
    .parent          (parent),
    .depth           (depth),
    .other_node      (other_node),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .common_ancestor (common_ancestor),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always #4 clk = ~clk;

  lca_scoreboard sb;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_trigger    = 0;
  int hold_seen       = 0;
  int hold_left       = 0;
  int cycles          = 0;
  int words_sent      = 0;
  int node_count_now  = NODE_COUNT_RST;

  // Nodes whose depth has been written; only these may be queried.
  bit depth_known [TREE_NODES];
  int known_nodes [$];

  // Abort a run that hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Output side: random stalls, plus a long hold on request so the block
  // fills up and drops in_ready while words keep coming.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_trigger) begin
      hold_seen <= hold_trigger;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Sample all three handshakes in one place so their order is fixed.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_node_count(cfg_data);
      if (in_valid && in_ready) sb.note_word(opcode, node, parent, depth, other_node);
      if (out_valid && out_ready) sb.check_result(common_ancestor);
    end
  end

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------

  // Offer one word and hold it until accepted; idle first when asked.
  task automatic send_word(int op, int n, int p, int d, int o);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= OP_W'(op);
    node       <= NODE_W'(n);
    parent     <= NODE_W'(p);
    depth      <= DEPTH_W'(d);
    other_node <= NODE_W'(o);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_UNUSED) return;
    words_sent++;
    if (op == OP_LOAD && !depth_known[n & (TREE_NODES-1)]) begin
      depth_known[n & (TREE_NODES-1)] = 1'b1;
      known_nodes.push_back(n & (TREE_NODES-1));
    end
  endtask

  function automatic int any_known();
    return known_nodes[$urandom_range(0, known_nodes.size()-1)];
  endfunction

  // Drop valid, drain every expected word, then allow a full build to end.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat ((TREE_LEVELS-1)*(1 + 2*node_count_now) + 64) @(posedge clk);
  endtask

  task automatic write_config(int value);
    cfg_valid <= 1'b1;
    cfg_data  <= NODE_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    node_count_now = value;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      IDLE_SENDER:   begin sender_idle_pct = 70; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  recv_stall_pct = 70; end
      IDLE_BOTH:     begin sender_idle_pct = 7;  recv_stall_pct = 7;  end
      default:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // Now and then slip in an ignored word, a stray load or a stale query.
  task automatic maybe_noise();
    int pick;
    if ($urandom_range(99) >= 6) return;
    pick = $urandom_range(2);
    case (pick)
      0: send_word(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
      1: send_word(OP_LOAD, $urandom_range(1, TREE_NODES-1), $urandom_range(0, TREE_NODES-1),
                   $urandom_range(0, 2047), $urandom);
      default: send_word(OP_QUERY, any_known(), $urandom, $urandom, any_known());
    endcase
  endtask

  // Load one random tree root first, build its levels, then query it.
  task automatic grow_and_query(bit squeeze);
    int hi, size, j, k, nq, a, b;
    int label [64];
    int tdep  [64];
    bit taken [TREE_NODES];
    hi   = (node_count_now < 8) ? 63 : node_count_now;
    size = $urandom_range(2, (hi + 1 < 48) ? hi + 1 : 48);
    label[0] = 0;
    tdep[0]  = 1;
    send_word(OP_LOAD, 0, 0, 1, $urandom);
    for (j = 1; j < size; j++) begin
      do k = $urandom_range(1, hi); while (taken[k]);
      taken[k] = 1'b1;
      label[j] = k;
      // Mix long chains with bushy fan-out.
      k = $urandom_range(1) ? j - 1 : $urandom_range(0, j - 1);
      tdep[j] = tdep[k] + 1;
      maybe_noise();
      send_word(OP_LOAD, label[j], label[k], tdep[j], $urandom);
    end
    maybe_noise();
    send_word(OP_BUILD, $urandom, $urandom, $urandom, $urandom);
    nq = $urandom_range(size, 3*size);
    for (j = 0; j < nq; j++) begin
      maybe_noise();
      if ($urandom_range(9) < 8) begin
        a = label[$urandom_range(0, size-1)];
        b = label[$urandom_range(0, size-1)];
      end else begin
        a = any_known();
        b = any_known();
      end
      send_word(OP_QUERY, a, $urandom, $urandom, b);
      // Start the long hold once the build is done and results begin to flow.
      if (squeeze && j == 0) hold_trigger++;
    end
  endtask

  task automatic run_phase(int count_cfg, int mode, bit squeeze);
    int start;
    bit first;
    settle();
    write_config(count_cfg);
    set_idling(mode);
    start = words_sent;
    first = squeeze;
    while (words_sent - start < PHASE_WORDS) begin
      grow_and_query(first);
      first = 1'b0;
    end
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    sb         = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    opcode     = OP_LOAD;
    node       = '0;
    parent     = '0;
    depth      = '0;
    other_node = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words at the reset node_count: small tree, queries before and
    // after a build, ignored opcode, extreme field values.
    send_word(OP_LOAD, 0, 0, 1, 0);
    send_word(OP_LOAD, 1023, 0, 2, 0);
    send_word(OP_LOAD, 1, 0, 2, 0);
    send_word(OP_LOAD, 2, 1, 3, 0);
    send_word(OP_LOAD, 3, 2, 4, 0);
    send_word(OP_LOAD, 4, 1, 3, 0);
    send_word(OP_QUERY, 3, 0, 0, 4);       // levels above the parent still root
    send_word(OP_BUILD, 0, 0, 0, 0);
    send_word(OP_QUERY, 3, 0, 0, 4);
    send_word(OP_QUERY, 4, 0, 0, 3);       // deeper node given second
    send_word(OP_QUERY, 0, 0, 0, 0);
    send_word(OP_QUERY, 1023, 1023, 2047, 1023);
    send_word(OP_QUERY, 3, 0, 0, 1023);
    send_word(OP_QUERY, 2, 0, 0, 3);       // one node is the other's ancestor
    send_word(OP_UNUSED, 1023, 1023, 2047, 1023);
    send_word(OP_LOAD, 5, 1023, 2047, 1023);
    send_word(OP_QUERY, 5, 0, 0, 0);       // depth gap wider than the levels
    send_word(OP_QUERY, 1023, 0, 0, 5);
    send_word(OP_LOAD, 6, 3, 1024, 0);
    send_word(OP_BUILD, 1023, 1023, 2047, 1023);
    send_word(OP_QUERY, 6, 0, 0, 4);
    settle();
    write_config(0);                       // build now fills no node
    send_word(OP_BUILD, 0, 0, 0, 0);
    send_word(OP_LOAD, 2, 4, 4, 0);
    send_word(OP_QUERY, 3, 0, 0, 4);
    send_word(OP_QUERY, 2, 0, 0, 1);

    // Random trees across node_count settings and idling patterns.
    run_phase(40,   IDLE_NONE,     1'b1);
    run_phase(1023, IDLE_SENDER,   1'b0);
    run_phase(120,  IDLE_RECEIVER, 1'b0);
    run_phase(0,    IDLE_BOTH,     1'b0);
    run_phase(500,  IDLE_RECEIVER, 1'b1);
    run_phase(255,  IDLE_BOTH,     1'b0);

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lcab_pkg.sv
rtl/lcab_ram.sv
rtl/lcab_seq.sv
rtl/lca_binary_lifting.sv
rtl/lcab_chk.sv
test/tb_lca_binary_lifting.sv
